// File: sv/rklb_pkg.sv
// Shared types and codes for the replicated key load balancer.
// No dependencies.
package rklb_pkg;

  typedef enum logic [3:0] {
    OP_GET         = 4'd0,
    OP_PUT         = 4'd1,
    OP_DEL         = 4'd2,
    OP_RD_REP      = 4'd3,
    OP_WR_REP      = 4'd4,
    OP_MIGRATE_REQ = 4'd5,
    OP_MIGRATE_ACK = 4'd6,
    OP_FORWARD_PUT = 4'd7,
    OP_INSTALL     = 4'd8,
    OP_REMOVE      = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ACT_DROP      = 3'd0,
    ACT_SERVER    = 3'd1,
    ACT_CLIENT    = 3'd2,
    ACT_REPLICATE = 3'd3,
    ACT_ERROR     = 3'd4
  } act_t;

  localparam logic [0:0] REG_NUM_SERVERS = 1'b0;
  localparam logic [0:0] REG_NODE_COUNT  = 1'b1;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_DIV,
    BE_LIST,
    BE_OUT
  } be_state_t;

  // Header item carried through the queue
  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] keyhash;
    logic [7:0]  client_node;
    logic [4:0]  server_num;
    logic [31:0] version;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  destination;
    logic [4:0]  new_server_id;
    logic [31:0] new_version;
    logic        replicated_key;
  } rsp_t;

endpackage

// File: sv/rklb_queue.sv
// Front part: accepts request items into a two-entry queue.
// Depends on rklb_pkg.
module rklb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rklb_pkg::req_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rklb_pkg::req_t out_item
);
  import rklb_pkg::*;

  req_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: sv/rklb_divider.sv
// Iterative 32-bit by 6-bit remainder unit, one bit per cycle.
// Depends on rklb_pkg.
module rklb_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [5:0]  divisor,
  output logic        done,
  output logic [5:0]  remainder
);
  import rklb_pkg::*;

  logic [31:0] quot;
  logic [6:0]  rem;
  logic [5:0]  dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [6:0]  trial;

  assign trial     = {rem[5:0], quot[31]};
  assign remainder = rem[5:0];

  // Shift one dividend bit per cycle into the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= 7'd0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[30:0], 1'b0};
      rem  <= (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;
    end
  end
endmodule

// File: sv/rklb_engine.sv
// Back part: table lookup, remainder, replica list access and update.
// Depends on rklb_pkg and rklb_divider.
module rklb_engine #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MAX_SERVERS   = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rklb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rklb_pkg::rsp_t rsp,
  input  logic [5:0]     num_servers,
  input  logic [5:0]     node_count
);
  import rklb_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);
  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  // Table storage; each entry owns a power-of-two slice of the list memory
  logic [TABLE_ENTRIES-1:0] ent_valid;
  logic [31:0]      ent_key  [TABLE_ENTRIES];
  logic [31:0]      ent_ver  [TABLE_ENTRIES];
  logic [31:0]      ent_map  [TABLE_ENTRIES];
  logic [CW-1:0]    ent_cnt  [TABLE_ENTRIES];
  logic [4:0]       list_mem [TABLE_ENTRIES << SW];

  be_state_t state, state_next;
  req_t      cur;
  rsp_t      out;
  logic [31:0] rr_cnt, ver_cnt;

  // Lookup results, registered
  logic          hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;
  logic [31:0]   e_ver, e_map;
  logic [CW-1:0] e_cnt;

  // Combinational search over the valid bits (independent compares)
  logic          s_hit, s_free;
  logic [IW-1:0] s_hit_idx, s_free_idx;
  always_comb begin
    s_hit = 1'b0; s_free = 1'b0;
    s_hit_idx = '0; s_free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (ent_valid[i] && ent_key[i] == cur.keyhash) begin
        s_hit = 1'b1; s_hit_idx = IW'(i);
      end
      if (!ent_valid[i]) begin
        s_free = 1'b1; s_free_idx = IW'(i);
      end
    end
  end

  // Saturated divisors
  logic [5:0] ns_sat, nn_sat;
  always_comb begin
    ns_sat = num_servers;
    if (ns_sat == 6'd0) ns_sat = 6'd1;
    if (ns_sat > 6'(MAX_SERVERS)) ns_sat = 6'(MAX_SERVERS);
    nn_sat = node_count;
    if (nn_sat == 6'd0) nn_sat = 6'd1;
    if (nn_sat > 6'd32) nn_sat = 6'd32;
  end

  logic        div_start, div_done;
  logic [31:0] div_a;
  logic [5:0]  div_b, div_rem;
  logic        need_div;

  rklb_divider u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .remainder(div_rem)
  );

  // Pick divide operands by operation
  always_comb begin
    need_div = 1'b0;
    div_a    = rr_cnt;
    div_b    = 6'd1;
    case (op_t'(cur.operation))
      OP_GET: begin
        need_div = s_hit && ent_cnt[s_hit_idx] != '0;
        div_b    = 6'(ent_cnt[s_hit_idx]);
      end
      OP_PUT, OP_DEL: begin
        need_div = s_hit;
        div_b    = ns_sat;
      end
      OP_INSTALL: begin
        need_div = !s_hit && s_free;
        div_a    = cur.keyhash;
        div_b    = nn_sat;
      end
      default: need_div = 1'b0;
    endcase
  end

  logic       list_rd;
  logic [4:0] list_q;
  logic [IW+SW-1:0] list_raddr;
  assign list_raddr = {hit_idx, SW'(div_rem)};

  // Registered list read
  always_ff @(posedge clk) begin
    if (list_rd) list_q <= list_mem[list_raddr];
  end

  logic [4:0] home;
  assign home = div_rem[4:0];

  // Sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    list_rd    = 1'b0;
    req_ready  = 1'b0;
    case (state)
      BE_IDLE: if (req_valid) state_next = BE_READ;
      BE_READ: begin
        req_ready = 1'b1;
        if (need_div) begin
          div_start  = 1'b1;
          state_next = BE_DIV;
        end else begin
          state_next = BE_OUT;
        end
      end
      BE_DIV: if (div_done) begin
        if (op_t'(cur.operation) == OP_GET) begin
          list_rd    = 1'b1;
          state_next = BE_LIST;
        end else begin
          state_next = BE_OUT;
        end
      end
      BE_LIST: state_next = BE_OUT;
      BE_OUT:  if (rsp_ready) state_next = BE_IDLE;
      default: state_next = BE_IDLE;
    endcase
  end

  assign rsp_valid = (state == BE_OUT);
  assign rsp       = out;

  always_ff @(posedge clk) begin
    if (rst) state <= BE_IDLE;
    else     state <= state_next;
  end

  // Capture current item
  always_ff @(posedge clk) begin
    if (state == BE_IDLE && req_valid) cur <= req;
  end

  logic        rf_bit;
  logic [31:0] rf_mask;
  assign rf_mask = 32'd1 << cur.server_num;
  assign rf_bit  = |(e_map & rf_mask);

  // Result fields known at lookup time; header echoed by default
  rsp_t lk_out;
  always_comb begin
    lk_out.action         = ACT_ERROR;
    lk_out.destination    = 8'd0;
    lk_out.new_server_id  = cur.server_num;
    lk_out.new_version    = cur.version;
    lk_out.replicated_key = s_hit;
    case (op_t'(cur.operation))
      OP_GET, OP_MIGRATE_REQ: begin
        lk_out.action      = ACT_SERVER;
        lk_out.destination = {3'd0, cur.server_num};
      end
      OP_PUT, OP_DEL: begin
        lk_out.action      = ACT_SERVER;
        lk_out.destination = {3'd0, cur.server_num};
        lk_out.new_version = ver_cnt;
      end
      OP_RD_REP, OP_WR_REP: begin
        lk_out.action      = ACT_CLIENT;
        lk_out.destination = cur.client_node;
      end
      OP_MIGRATE_ACK: lk_out.action = ACT_DROP;
      OP_INSTALL:     lk_out.action = s_hit ? ACT_DROP : ACT_ERROR;
      OP_REMOVE:      lk_out.action = ACT_DROP;
      default:        lk_out.action = ACT_ERROR;
    endcase
  end

  // Decide result and update state
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rr_cnt    <= 32'd0;
      ver_cnt   <= 32'd1;
    end else begin
      if (state == BE_READ) begin
        hit      <= s_hit;
        hit_idx  <= s_hit_idx;
        free_ok  <= s_free;
        free_idx <= s_free_idx;
        e_ver    <= ent_ver[s_hit_idx];
        e_map    <= ent_map[s_hit_idx];
        e_cnt    <= ent_cnt[s_hit_idx];
        out      <= lk_out;
        if (op_t'(cur.operation) == OP_PUT || op_t'(cur.operation) == OP_DEL)
          ver_cnt <= ver_cnt + 32'd1;
        if (op_t'(cur.operation) == OP_REMOVE && s_hit)
          ent_valid[s_hit_idx] <= 1'b0;
      end
      if (state == BE_DIV && div_done) begin
        case (op_t'(cur.operation))
          OP_PUT, OP_DEL: begin
            out.new_server_id <= home;
            out.destination   <= {3'd0, home};
            rr_cnt            <= rr_cnt + 32'd1;
          end
          OP_INSTALL: begin
            ent_valid[free_idx] <= 1'b1;
            out.action          <= ACT_REPLICATE;
            out.destination     <= {3'd0, home};
            out.new_server_id   <= home;
            out.new_version     <= 32'd0;
          end
          default: ;
        endcase
      end
      if (state == BE_LIST) begin
        out.new_server_id <= list_q;
        out.destination   <= {3'd0, list_q};
        rr_cnt            <= rr_cnt + 32'd1;
      end
    end
  end

  // Table payload writes: install and replica refresh
  logic refresh_op;
  assign refresh_op = op_t'(cur.operation) == OP_RD_REP ||
                      op_t'(cur.operation) == OP_WR_REP ||
                      op_t'(cur.operation) == OP_MIGRATE_ACK;

  always_ff @(posedge clk) begin
    if (state == BE_DIV && div_done && op_t'(cur.operation) == OP_INSTALL) begin
      ent_key[free_idx]  <= cur.keyhash;
      ent_ver[free_idx]  <= 32'd0;
      ent_map[free_idx]  <= 32'd1 << home;
      ent_cnt[free_idx]  <= CW'(1);
      list_mem[{free_idx, SW'(0)}] <= home;
    end else if (state == BE_OUT && state_next == BE_IDLE && refresh_op && hit) begin
      if (cur.version > e_ver) begin
        ent_ver[hit_idx] <= cur.version;
        ent_map[hit_idx] <= rf_mask;
        ent_cnt[hit_idx] <= CW'(1);
        list_mem[{hit_idx, SW'(0)}] <= cur.server_num;
      end else if (cur.version == e_ver && !rf_bit && e_cnt < CW'(MAX_SERVERS)) begin
        ent_map[hit_idx] <= e_map | rf_mask;
        ent_cnt[hit_idx] <= e_cnt + CW'(1);
        list_mem[{hit_idx, SW'(e_cnt)}] <= cur.server_num;
      end
    end
  end
endmodule

// File: sv/replicated_key_load_balancer_unit.sv
// Top level of the replicated key load balancer: config registers,
// request queue and back-end engine. Depends on rklb_pkg, rklb_queue, rklb_engine.
//
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       operation keyhash client_node server_num
//                                                version
// out       output     out_valid / out_ready     action destination new_server_id new_version
//                                                replicated_key
// cfg       input      cfg_valid / cfg_ready     cfg_index cfg_data
//
// Sequence: the engine does capture, lookup and result on an item that needs no
// remainder; put and del on a replicated key and install into
// a free slot add the 32-step remainder unit, and a get on a
// replicated key adds its list read after that.
// The result register holds until out_ready; the two-entry queue keeps
// accepting items while it has room. Reset clears valid bits and rr_cnt and sets ver_cnt to 1.
module replicated_key_load_balancer_unit #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MAX_SERVERS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [31:0] keyhash,
  input  logic [7:0]  client_node,
  input  logic [4:0]  server_num,
  input  logic [31:0] version,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  destination,
  output logic [4:0]  new_server_id,
  output logic [31:0] new_version,
  output logic        replicated_key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import rklb_pkg::*;

  logic [5:0] num_servers, node_count;
  req_t in_item, q_item;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= 6'd32;
      node_count  <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_SERVERS: num_servers <= cfg_data;
        REG_NODE_COUNT:  node_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = '{operation: operation, keyhash: keyhash, client_node: client_node,
                     server_num: server_num, version: version};

  rklb_queue u_queue (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  rklb_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_SERVERS(MAX_SERVERS)) u_engine (
    .clk, .rst, .req_valid(q_valid), .req_ready(q_ready), .req(q_item),
    .rsp_valid(out_valid), .rsp_ready(out_ready), .rsp,
    .num_servers, .node_count
  );

  assign action         = rsp.action;
  assign destination    = rsp.destination;
  assign new_server_id  = rsp.new_server_id;
  assign new_version    = rsp.new_version;
  assign replicated_key = rsp.replicated_key;
endmodule

// File: sv/rklb_checker.sv
// Port-level checks for the load balancer top level, with its bind.
// Depends on rklb_pkg.
module rklb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic [7:0]  destination,
  input logic        cfg_ready
);
  import rklb_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action))
    else $error("result changed while stalled");

  // Drop and error carry destination zero
  a_dst: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_DROP || action == ACT_ERROR) |-> destination == 8'd0)
    else $error("nonzero destination on drop or error");

  // Action code in range
  a_act: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> action <= ACT_ERROR)
    else $error("bad action");

  // No result right out of reset
  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");
endmodule

bind replicated_key_load_balancer_unit rklb_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .action, .destination, .cfg_ready
);
